// ===== sv/aft_pkg.sv =====
`timescale 1ns / 1ps

package aft_pkg;

   localparam logic [1:0] FN_INSERT = 2'd0;
   localparam logic [1:0] FN_LOOKUP = 2'd1;
   localparam logic [1:0] FN_TICK   = 2'd2;
   localparam logic [1:0] FN_PURGE  = 2'd3;

   localparam logic [15:0] HITS_MAX      = 16'hFFFF;
   localparam logic [31:0] EXPIRY_RESET  = 32'd1000;

   typedef struct packed {
      logic [1:0]  func;
      logic [31:0] attacker_ip;
      logic [31:0] victim_ip;
   } req_type;

   typedef struct packed {
      logic [15:0] hit_count;
      logic        status;
      logic [4:0]  purged;
   } rsp_type;

   typedef struct packed {
      logic [31:0] attacker_ip;
      logic [31:0] victim_ip;
      logic [31:0] start_ms;
      logic [15:0] hits;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic bump;
   } cell_ctrl_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

endpackage

// ===== sv/aft_cell.sv =====
`timescale 1ns / 1ps

module aft_cell (
   input  logic                   clock,
   input  aft_pkg::cell_ctrl_type ctrl,
   input  aft_pkg::entry_type     next_entry,
   input  aft_pkg::entry_type     load_entry,
   input  logic [31:0]            key_attacker,
   input  logic [31:0]            key_victim,
   output aft_pkg::entry_type     entry,
   output logic                   match
);

   aft_pkg::entry_type entry_ff;
   aft_pkg::entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.shift) begin
         entry_in = next_entry;
      end else if (ctrl.load) begin
         entry_in = load_entry;
      end else if (ctrl.bump && (entry_ff.hits != aft_pkg::HITS_MAX)) begin
         entry_in.hits = entry_ff.hits + 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign match = (entry_ff.attacker_ip == key_attacker) && (entry_ff.victim_ip == key_victim);

endmodule

// ===== sv/aging_flow_hit_table_unit.sv =====
`timescale 1ns / 1ps

// Flow table of TABLE_DEPTH entries held oldest-first in a row of cells.
// A request is taken when start is high and busy is low; its one response
// appears on rsp_data for a single cycle with rsp_valid and cannot be stalled,
// so the receiver must sample it then. Insert, lookup and tick return to idle
// after ST_EXEC; purge stays in ST_EXEC while the head is expired, each removal
// shifting the whole cell row by one toward the oldest end, one entry per cycle.
// Lookup compares all cells at once and picks the oldest live match.
// The user must write expiry_ms through csr_valid and csr_wdata only while no
// request is in flight; the block does not enforce it. csr_ready is always high.
module aging_flow_hit_table_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  aft_pkg::req_type req_data,
   output logic             rsp_valid,
   output aft_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [31:0]      csr_wdata
);

   localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

   aft_pkg::state_type state_ff, state_in;
   aft_pkg::req_type   req_ff, req_in;
   aft_pkg::rsp_type   rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic [OCC_W-1:0]   pcount_ff, pcount_in;
   logic [31:0]        now_ff, now_in;
   logic [31:0]        expiry_ff, expiry_in;

   aft_pkg::entry_type     entries   [TABLE_DEPTH];
   aft_pkg::entry_type     nbr       [TABLE_DEPTH];
   aft_pkg::cell_ctrl_type ctrl      [TABLE_DEPTH];
   aft_pkg::entry_type     new_entry;
   logic [TABLE_DEPTH-1:0] match;
   logic [TABLE_DEPTH-1:0] live_match;
   logic [TABLE_DEPTH-1:0] first;
   logic [15:0]            hit_sel;
   logic [31:0]            head_age;
   logic                   head_expired;
   logic                   exec;
   logic                   full;
   logic                   do_insert;
   logic                   do_purge;

   assign exec         = (state_ff == aft_pkg::ST_EXEC);
   assign full         = (occ_ff == OCC_W'(TABLE_DEPTH));
   assign head_age     = now_ff - entries[0].start_ms;
   assign head_expired = (occ_ff != '0) && (head_age > expiry_ff);
   assign do_insert    = exec && (req_ff.func == aft_pkg::FN_INSERT) && !full;
   assign do_purge     = exec && (req_ff.func == aft_pkg::FN_PURGE) && head_expired;

   always_comb begin
      new_entry.attacker_ip = req_ff.attacker_ip;
      new_entry.victim_ip   = req_ff.victim_ip;
      new_entry.start_ms    = now_ff;
      new_entry.hits        = 16'd1;
   end

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      if (i == TABLE_DEPTH - 1) begin : g_last
         assign nbr[i] = entries[i];
      end else begin : g_mid
         assign nbr[i] = entries[i+1];
      end

      assign live_match[i] = match[i] && (OCC_W'(i) < occ_ff);
      assign ctrl[i].shift = do_purge;
      assign ctrl[i].load  = do_insert && (occ_ff == OCC_W'(i));
      assign ctrl[i].bump  = exec && (req_ff.func == aft_pkg::FN_LOOKUP) && first[i];

      aft_cell u_cell (
         .clock        (clock),
         .ctrl         (ctrl[i]),
         .next_entry   (nbr[i]),
         .load_entry   (new_entry),
         .key_attacker (req_ff.attacker_ip),
         .key_victim   (req_ff.victim_ip),
         .entry        (entries[i]),
         .match        (match[i])
      );
   end

   // oldest live match: lowest set bit
   assign first = live_match & (~live_match + TABLE_DEPTH'(1));

   always_comb begin
      hit_sel = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         hit_sel = hit_sel | (first[i] ? entries[i].hits : 16'd0);
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      occ_in       = occ_ff;
      pcount_in    = pcount_ff;
      now_in       = now_ff;
      expiry_in    = expiry_ff;

      if (csr_valid) begin
         expiry_in = csr_wdata;
      end

      unique case (state_ff)
         aft_pkg::ST_IDLE: begin
            if (start) begin
               req_in    = req_data;
               pcount_in = '0;
               state_in  = aft_pkg::ST_EXEC;
            end
         end
         aft_pkg::ST_EXEC: begin
            rsp_in.hit_count = 16'd0;
            rsp_in.status    = 1'b0;
            rsp_in.purged    = 5'd0;
            case (req_ff.func)
               aft_pkg::FN_INSERT: begin
                  if (full) begin
                     rsp_in.status = 1'b1;
                  end else begin
                     occ_in = occ_ff + OCC_W'(1);
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = aft_pkg::ST_IDLE;
               end
               aft_pkg::FN_LOOKUP: begin
                  rsp_in.hit_count = hit_sel;
                  rsp_valid_in     = 1'b1;
                  state_in         = aft_pkg::ST_IDLE;
               end
               aft_pkg::FN_TICK: begin
                  now_in       = now_ff + 32'd1;
                  rsp_valid_in = 1'b1;
                  state_in     = aft_pkg::ST_IDLE;
               end
               default: begin
                  if (head_expired) begin
                     occ_in    = occ_ff - OCC_W'(1);
                     pcount_in = pcount_ff + OCC_W'(1);
                  end else begin
                     rsp_in.purged = 5'(pcount_ff);
                     rsp_valid_in  = 1'b1;
                     state_in      = aft_pkg::ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = aft_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= aft_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         pcount_ff    <= '0;
         now_ff       <= '0;
         expiry_ff    <= aft_pkg::EXPIRY_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         occ_ff       <= occ_in;
         pcount_ff    <= pcount_in;
         now_ff       <= now_in;
         expiry_ff    <= expiry_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != aft_pkg::ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(TABLE_DEPTH))
      else $error("occupancy beyond table depth");

   a_rsp_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == aft_pkg::ST_EXEC))
      else $error("response without execution");

   a_drop_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status) |-> (occ_ff == OCC_W'(TABLE_DEPTH)))
      else $error("insert dropped while table not full");

   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      exec |-> $onehot0(first))
      else $error("more than one lookup hit selected");

endmodule
